[sv/swbf_pkg.sv]
// ----------------------------------------------------------------------------
// swbf_pkg
// Shared constants and saturation helpers for the boundary flux pipeline.
// ----------------------------------------------------------------------------
package swbf_pkg;

    localparam int unsigned QW       = 32;
    localparam int unsigned HW       = 31;
    localparam int unsigned DIV_NUMW = 48;
    localparam int unsigned DIV_DENW = 31;
    localparam int unsigned DIV_QW   = 48;

    localparam logic signed [QW-1:0] QMAX = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] QMIN = 32'sh8000_0000;

    localparam logic [HW-1:0] GRAVITY_RESET = 31'd642908;

    typedef enum logic [0:0] {
        REG_GRAVITY = 1'b0,
        REG_FLIP    = 1'b1
    } t_reg_idx;

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic signed [QW-1:0] sat_to_q(input logic signed [79:0] x);
        logic signed [79:0] hi;
        logic signed [79:0] lo;
        begin
            hi = 80'(QMAX);
            lo = 80'(QMIN);
            if (x > hi) begin
                sat_to_q = QMAX;
            end else if (x < lo) begin
                sat_to_q = QMIN;
            end else begin
                sat_to_q = x[QW-1:0];
            end
        end
    endfunction

    // Q16.16 product, floor toward minus infinity (arithmetic shift).
    function automatic logic signed [79:0] mulq(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
        logic signed [63:0] p;
        begin
            p = a * b;
            mulq = 80'(p >>> 16);
        end
    endfunction

endpackage

[sv/swbf_div.sv]
// ----------------------------------------------------------------------------
// swbf_div
// Pipelined restoring divider: one quotient bit per stage, truncating,
// with sign fixup and saturation of the quotient.
// ----------------------------------------------------------------------------
module swbf_div (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [swbf_pkg::QW-1:0]    i_num,
    input  logic        [swbf_pkg::HW-1:0]    i_den,
    output logic signed [swbf_pkg::QW-1:0]    o_quot
);
    import swbf_pkg::*;

    localparam int unsigned NST = DIV_QW;

    logic [DIV_NUMW-1:0] r_num [NST+1];
    logic [DIV_DENW:0]   r_rem [NST+1];
    logic [DIV_DENW-1:0] r_den [NST+1];
    logic                r_neg [NST+1];

    // Stage zero captures the magnitude of mom * 2^16.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= i_num[QW-1] ? DIV_NUMW'({16'(0), -i_num} << 16)
                                    : DIV_NUMW'({16'(0), i_num} << 16);
            r_rem[0] <= '0;
            r_den[0] <= (i_den == '0) ? DIV_DENW'(1) : i_den;
            r_neg[0] <= i_num[QW-1];
        end
    end

    // One quotient bit per stage; the quotient shifts into the numerator.
    for (genvar s = 0; s < NST; s++) begin : g_st
        logic [DIV_DENW+1:0] trial;
        logic [DIV_DENW+1:0] diff;
        assign trial = {r_rem[s], r_num[s][DIV_NUMW-1]};
        assign diff  = trial - {1'b0, 1'b0, r_den[s]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s+1] <= r_den[s];
                r_neg[s+1] <= r_neg[s];
                if (!diff[DIV_DENW+1]) begin
                    r_rem[s+1] <= diff[DIV_DENW:0];
                    r_num[s+1] <= {r_num[s][DIV_NUMW-2:0], 1'b1};
                end else begin
                    r_rem[s+1] <= trial[DIV_DENW:0];
                    r_num[s+1] <= {r_num[s][DIV_NUMW-2:0], 1'b0};
                end
            end
        end
    end

    // Apply sign and saturate the final quotient.
    logic signed [79:0] q_signed;
    assign q_signed = r_neg[NST] ? -80'(r_num[NST]) : 80'(r_num[NST]);
    assign o_quot   = sat_to_q(q_signed);

endmodule

[sv/shallow_water_boundary_flux.sv]
// ----------------------------------------------------------------------------
// shallow_water_boundary_flux
// Central shallow-water flux at a boundary face, added to the residuals.
// ----------------------------------------------------------------------------
// Stages: the input stage, 48 divider stages, five flux stages and the output
// register. Throughput: one transaction per cycle; the whole pipeline
// advances together and freezes while a result waits under a stall.
// Reset: synchronous, active low; clears valid bits and restores gravity to
// 9.81 and the normal flip to 0.
module shallow_water_boundary_flux (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [30:0]        i_ghost_depth,
    input  logic signed [31:0] i_ghost_xmom,
    input  logic signed [31:0] i_ghost_ymom,
    input  logic [30:0]        i_inner_depth,
    input  logic signed [31:0] i_inner_xmom,
    input  logic signed [31:0] i_inner_ymom,
    input  logic signed [31:0] i_normal_x,
    input  logic signed [31:0] i_normal_y,
    input  logic signed [31:0] i_resid_mass_in,
    input  logic signed [31:0] i_resid_xmom_in,
    input  logic signed [31:0] i_resid_ymom_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_resid_mass_out,
    output logic signed [31:0] o_resid_xmom_out,
    output logic signed [31:0] o_resid_ymom_out,
    output logic               o_zero_depth_fault
);
    import swbf_pkg::*;

    localparam int unsigned DL  = DIV_QW + 1;
    localparam int unsigned NPS = DL + 5;

    // Configuration registers.
    logic [HW-1:0] r_gravity;
    logic          r_flip;
    logic          wr_en;
    t_reg_idx      wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[1:0] == 2'b00);
    assign wr_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= GRAVITY_RESET;
            r_flip    <= 1'b0;
        end else if (wr_en) begin
            case (wr_idx)
                REG_GRAVITY: r_gravity <= pwdata[HW-1:0];
                REG_FLIP:    r_flip    <= pwdata[0];
                default:     r_flip    <= r_flip;
            endcase
        end
    end

    always_comb begin
        case (wr_idx)
            REG_GRAVITY: prdata = {1'b0, r_gravity};
            REG_FLIP:    prdata = {31'd0, r_flip};
            default:     prdata = '0;
        endcase
        if (paddr[1:0] != 2'b00) prdata = '0;
    end

    // Global advance: the pipeline moves when the output register is free.
    logic adv;
    logic r_ovalid;
    assign adv     = !r_ovalid || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_ovalid;

    logic r_v [NPS];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NPS; k++) r_v[k] <= 1'b0;
        end else if (adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < NPS; k++) r_v[k] <= r_v[k-1];
        end
    end

    // Dividers for the four velocities.
    logic signed [QW-1:0] ug, vg, ui, vi;
    swbf_div u_div_ug (.i_clk, .i_en(adv), .i_num(i_ghost_xmom), .i_den(i_ghost_depth), .o_quot(ug));
    swbf_div u_div_vg (.i_clk, .i_en(adv), .i_num(i_ghost_ymom), .i_den(i_ghost_depth), .o_quot(vg));
    swbf_div u_div_ui (.i_clk, .i_en(adv), .i_num(i_inner_xmom), .i_den(i_inner_depth), .o_quot(ui));
    swbf_div u_div_vi (.i_clk, .i_en(adv), .i_num(i_inner_ymom), .i_den(i_inner_depth), .o_quot(vi));

    // Side data delay line matching the divider latency.
    typedef struct packed {
        logic [HW-1:0]        hg;
        logic [HW-1:0]        hi;
        logic signed [QW-1:0] sx;
        logic signed [QW-1:0] sy;
        logic signed [QW-1:0] rm;
        logic signed [QW-1:0] rx;
        logic signed [QW-1:0] ry;
        logic                 zf;
    } t_side;

    t_side n_side;
    t_side r_side [DL];
    logic signed [QW-1:0] fx, fy;

    always_comb begin
        fx = r_flip ? sat_to_q(-80'(i_normal_x)) : i_normal_x;
        fy = r_flip ? sat_to_q(-80'(i_normal_y)) : i_normal_y;
        n_side = '{hg: i_ghost_depth, hi: i_inner_depth, sx: fx, sy: fy,
                   rm: i_resid_mass_in, rx: i_resid_xmom_in, ry: i_resid_ymom_in,
                   zf: (i_ghost_depth == '0) || (i_inner_depth == '0)};
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_side[0] <= n_side;
            for (int k = 1; k < DL; k++) r_side[k] <= r_side[k-1];
        end
    end

    t_side sd;
    assign sd = r_side[DL-1];

    // Flux stage A: dot-product terms and squared depths.
    logic signed [QW-1:0] r_a_ug, r_a_vg, r_a_ui, r_a_vi;
    logic signed [79:0]   r_a_tg1, r_a_tg2, r_a_ti1, r_a_ti2, r_a_sg, r_a_si;
    t_side r_a;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a     <= sd;
            r_a_ug  <= ug; r_a_vg <= vg; r_a_ui <= ui; r_a_vi <= vi;
            r_a_tg1 <= mulq(ug, sd.sx);
            r_a_tg2 <= mulq(vg, sd.sy);
            r_a_ti1 <= mulq(ui, sd.sx);
            r_a_ti2 <= mulq(vi, sd.sy);
            r_a_sg  <= mulq({1'b0, sd.hg}, {1'b0, sd.hg});
            r_a_si  <= mulq({1'b0, sd.hi}, {1'b0, sd.hi});
        end
    end

    // Flux stage B: saturated dot products and squared-depth sum.
    logic signed [QW-1:0] r_b_dg, r_b_di, r_b_sq;
    logic signed [QW-1:0] r_b_ug, r_b_vg, r_b_ui, r_b_vi;
    t_side r_b;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b    <= r_a;
            r_b_ug <= r_a_ug; r_b_vg <= r_a_vg; r_b_ui <= r_a_ui; r_b_vi <= r_a_vi;
            r_b_dg <= sat_to_q(r_a_tg1 + r_a_tg2);
            r_b_di <= sat_to_q(r_a_ti1 + r_a_ti2);
            r_b_sq <= sat_to_q(r_a_sg + r_a_si);
        end
    end

    // Flux stage C: face discharge per side and the pressure product.
    logic signed [QW-1:0] r_c_qg, r_c_qi;
    logic signed [63:0]   r_c_gp;
    logic signed [QW-1:0] r_c_ug, r_c_vg, r_c_ui, r_c_vi;
    t_side r_c;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c    <= r_b;
            r_c_ug <= r_b_ug; r_c_vg <= r_b_vg; r_c_ui <= r_b_ui; r_c_vi <= r_b_vi;
            r_c_qg <= sat_to_q(mulq(r_b_dg, {1'b0, r_b.hg}));
            r_c_qi <= sat_to_q(mulq(r_b_di, {1'b0, r_b.hi}));
            r_c_gp <= $signed({1'b0, r_gravity}) * r_b_sq;
        end
    end

    // Flux stage D: momentum flux products and scaled pressure.
    logic signed [79:0]   r_d_xg, r_d_xi, r_d_yg, r_d_yi, r_d_mq;
    logic signed [QW-1:0] r_d_gh;
    t_side r_d;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d    <= r_c;
            r_d_xg <= mulq(r_c_qg, r_c_ug);
            r_d_xi <= mulq(r_c_qi, r_c_ui);
            r_d_yg <= mulq(r_c_qg, r_c_vg);
            r_d_yi <= mulq(r_c_qi, r_c_vi);
            r_d_mq <= 80'(r_c_qg) + 80'(r_c_qi);
            r_d_gh <= sat_to_q(80'(r_c_gp >>> 18));
        end
    end

    // Flux stage E: pressure terms along the normal and halved flux sums.
    logic signed [79:0] r_e_px, r_e_py, r_e_hx, r_e_hy, r_e_hm;
    t_side r_e;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e    <= r_d;
            r_e_px <= mulq(r_d_gh, r_d.sx);
            r_e_py <= mulq(r_d_gh, r_d.sy);
            r_e_hx <= (r_d_xg + r_d_xi) >>> 1;
            r_e_hy <= (r_d_yg + r_d_yi) >>> 1;
            r_e_hm <= r_d_mq >>> 1;
        end
    end

    // Output register: residual updates, zero-depth override.
    logic signed [QW-1:0] r_om, r_ox, r_oy;
    logic                 r_oz;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (adv) begin
            r_ovalid <= r_v[NPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_oz <= r_e.zf;
            if (r_e.zf) begin
                r_om <= QMAX; r_ox <= QMAX; r_oy <= QMAX;
            end else begin
                r_om <= sat_to_q(80'(r_e.rm) + r_e_hm);
                r_ox <= sat_to_q(80'(r_e.rx) + r_e_hx + r_e_px);
                r_oy <= sat_to_q(80'(r_e.ry) + r_e_hy + r_e_py);
            end
        end
    end

    assign o_resid_mass_out   = r_om;
    assign o_resid_xmom_out   = r_ox;
    assign o_resid_ymom_out   = r_oy;
    assign o_zero_depth_fault = r_oz;

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_resid_mass_out))
        else $error("result changed under stall");

    // A fault result always carries saturated residuals.
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_depth_fault |-> o_resid_mass_out == QMAX)
        else $error("fault without saturation");

    // Input is stalled only while a result waits.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("spurious input stall");

endmodule

[tb/shallow_water_boundary_flux_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shallow_water_boundary_flux_test
// Streams boundary faces through the flux pipeline, under several gravity and
// normal-flip settings and random idling on both channels, and checks every
// result against hand-set residuals or a Q16.16 flux calculation in the bench.
// ----------------------------------------------------------------------------
module shallow_water_boundary_flux_test;
    import swbf_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int DRAIN_CYCLES = 70;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int BLOCK_ITEMS  = 105;

    typedef struct packed {
        logic [30:0]        ghost_depth;
        logic signed [31:0] ghost_xmom;
        logic signed [31:0] ghost_ymom;
        logic [30:0]        inner_depth;
        logic signed [31:0] inner_xmom;
        logic signed [31:0] inner_ymom;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] resid_mass;
        logic signed [31:0] resid_xmom;
        logic signed [31:0] resid_ymom;
    } t_face;

    typedef struct packed {
        logic signed [31:0] resid_mass;
        logic signed [31:0] resid_xmom;
        logic signed [31:0] resid_ymom;
        logic               fault;
    } t_residual;

    typedef struct {
        t_face     face;
        bit        typed;
        t_residual want;
    } t_face_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_stall;
    t_face              face_in = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_resid_mass_out;
    logic signed [31:0] o_resid_xmom_out;
    logic signed [31:0] o_resid_ymom_out;
    logic               o_zero_depth_fault;

    // Register shadows used by the flux calculation.
    logic [30:0] gravity_shadow = GRAVITY_RESET;
    logic        flip_shadow = 1'b0;

    t_residual residual_queue[$];
    t_face_row pending_rows[$];
    int        failures = 0;
    int        faces_sent = 0;
    int        results_seen = 0;
    int        faults_seen = 0;
    int        stall_seen = 0;
    int        idle_mode = 0;
    int        cycles = 0;
    int        hold_count = 0;
    bit        hold_done = 1'b0;

    shallow_water_boundary_flux dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_ghost_depth(face_in.ghost_depth), .i_ghost_xmom(face_in.ghost_xmom),
        .i_ghost_ymom(face_in.ghost_ymom), .i_inner_depth(face_in.inner_depth),
        .i_inner_xmom(face_in.inner_xmom), .i_inner_ymom(face_in.inner_ymom),
        .i_normal_x(face_in.normal_x), .i_normal_y(face_in.normal_y),
        .i_resid_mass_in(face_in.resid_mass), .i_resid_xmom_in(face_in.resid_xmom),
        .i_resid_ymom_in(face_in.resid_ymom),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_resid_mass_out(o_resid_mass_out), .o_resid_xmom_out(o_resid_xmom_out),
        .o_resid_ymom_out(o_resid_ymom_out), .o_zero_depth_fault(o_zero_depth_fault)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Clamp to the signed 32-bit range.
    function automatic longint clamp_q(input longint x);
        if (x > longint'(QMAX)) return longint'(QMAX);
        if (x < longint'(QMIN)) return longint'(QMIN);
        return x;
    endfunction

    // Q16.16 product, rounded toward minus infinity.
    function automatic longint qmul(input longint a, input longint b);
        return (a * b) >>> 16;
    endfunction

    // Normal mass flux of one cell: (u.s) times depth.
    function automatic longint cell_discharge(input longint u, input longint v,
                                              input longint sx, input longint sy,
                                              input longint h);
        longint dot;
        dot = clamp_q(qmul(u, sx) + qmul(v, sy));
        return clamp_q(qmul(dot, h));
    endfunction

    // Central flux of one boundary face added to its residuals.
    function automatic t_residual face_flux(input t_face f);
        t_residual r;
        longint hg, hi, sx, sy, ug, vg, ui, vi, qg, qi, sq, gh;
        hg = longint'(f.ghost_depth);
        hi = longint'(f.inner_depth);
        if (hg == 0 || hi == 0) begin
            r.resid_mass = QMAX;
            r.resid_xmom = QMAX;
            r.resid_ymom = QMAX;
            r.fault = 1'b1;
            return r;
        end
        sx = longint'(f.normal_x);
        sy = longint'(f.normal_y);
        if (flip_shadow) begin
            sx = clamp_q(-sx);
            sy = clamp_q(-sy);
        end
        // Velocities truncate toward zero.
        ug = clamp_q((longint'(f.ghost_xmom) * 65536) / hg);
        vg = clamp_q((longint'(f.ghost_ymom) * 65536) / hg);
        ui = clamp_q((longint'(f.inner_xmom) * 65536) / hi);
        vi = clamp_q((longint'(f.inner_ymom) * 65536) / hi);
        qg = cell_discharge(ug, vg, sx, sy, hg);
        qi = cell_discharge(ui, vi, sx, sy, hi);
        // Pressure term: g/4 times the sum of the squared depths.
        sq = clamp_q(qmul(hg, hg) + qmul(hi, hi));
        gh = clamp_q((longint'(gravity_shadow) * sq) >>> 18);
        r.resid_mass = 32'(clamp_q(longint'(f.resid_mass) + ((qg + qi) >>> 1)));
        r.resid_xmom = 32'(clamp_q(longint'(f.resid_xmom)
                       + ((qmul(qg, ug) + qmul(qi, ui)) >>> 1) + qmul(gh, sx)));
        r.resid_ymom = 32'(clamp_q(longint'(f.resid_ymom)
                       + ((qmul(qg, vg) + qmul(qi, vi)) >>> 1) + qmul(gh, sy)));
        r.fault = 1'b0;
        return r;
    endfunction

    // Mostly moderate values, with the extremes mixed in.
    function automatic logic signed [31:0] random_q();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5) return QMAX;
        if (pick < 10) return QMIN;
        if (pick < 45) return $urandom();
        return $signed(32'($urandom_range(32'h0008_0000))) - 32'sh0004_0000;
    endfunction

    function automatic logic [30:0] random_depth();
        int pick;
        pick = $urandom_range(99);
        if (pick < 3) return '0;
        if (pick < 7) return 31'h7FFF_FFFF;
        if (pick < 30) return 31'($urandom());
        return 31'($urandom_range(32'h0006_0000, 1));
    endfunction

    function automatic t_face random_face();
        t_face f;
        f.ghost_depth = random_depth();
        f.ghost_xmom = random_q();
        f.ghost_ymom = random_q();
        f.inner_depth = random_depth();
        f.inner_xmom = random_q();
        f.inner_ymom = random_q();
        f.normal_x = random_q();
        f.normal_y = random_q();
        f.resid_mass = random_q();
        f.resid_xmom = random_q();
        f.resid_ymom = random_q();
        return f;
    endfunction

    // Record each accepted face and its expected residuals.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            if (pending_rows.size() > 0 && pending_rows[0].typed) begin
                residual_queue.push_back(pending_rows[0].want);
            end else begin
                residual_queue.push_back(face_flux(face_in));
            end
            if (pending_rows.size() > 0) begin
                void'(pending_rows.pop_front());
            end
            faces_sent <= faces_sent + 1;
        end
        if (i_rst_n && o_stall) begin
            stall_seen <= stall_seen + 1;
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_residual want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen <= results_seen + 1;
            if (residual_queue.size() == 0) begin
                $error("result transaction with nothing expected");
                failures <= failures + 1;
            end else begin
                want = residual_queue.pop_front();
                if (o_zero_depth_fault) begin
                    faults_seen <= faults_seen + 1;
                end
                if (o_resid_mass_out !== want.resid_mass) begin
                    $error("resid_mass_out expected %0d got %0d",
                           want.resid_mass, o_resid_mass_out);
                    failures <= failures + 1;
                end
                if (o_resid_xmom_out !== want.resid_xmom) begin
                    $error("resid_xmom_out expected %0d got %0d",
                           want.resid_xmom, o_resid_xmom_out);
                    failures <= failures + 1;
                end
                if (o_resid_ymom_out !== want.resid_ymom) begin
                    $error("resid_ymom_out expected %0d got %0d",
                           want.resid_ymom, o_resid_ymom_out);
                    failures <= failures + 1;
                end
                if (o_zero_depth_fault !== want.fault) begin
                    $error("zero_depth_fault expected %0b got %0b",
                           want.fault, o_zero_depth_fault);
                    failures <= failures + 1;
                end
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off when idling is off.
    always @(posedge i_clk) begin
        if (idle_mode == 2 && !hold_done && faces_sent > 0) begin
            i_stall <= 1'b1;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1) begin
                hold_done <= 1'b1;
            end
        end else if (idle_mode == 0) begin
            i_stall <= ($urandom_range(99) < 76);
        end else if (idle_mode == 1) begin
            i_stall <= ($urandom_range(99) < 14);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one face; returns once it is accepted.
    task automatic send_face(input t_face f);
        bit stalled;
        while ($urandom_range(99) < (idle_mode == 0 ? 14 : (idle_mode == 1 ? 76 : 0))) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        face_in <= f;
        do begin
            @(negedge i_clk);
            stalled = o_stall;
            @(posedge i_clk);
        end while (stalled);
    endtask

    // APB write: setup cycle then access cycle.
    task automatic write_register(input t_reg_idx idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * int'(idx));
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_GRAVITY) begin
            gravity_shadow = value[30:0];
        end else begin
            flip_shadow = value[0];
        end
    endtask

    // Let the pipeline empty before touching the registers. The wait starts
    // at the falling edge so that the last accepted face is already queued.
    task automatic drain_pipeline();
        i_valid <= 1'b0;
        @(negedge i_clk);
        wait (residual_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_face_row rows[$];
        t_face_row row;
        t_face f;
        logic [31:0] gravity_set[4];
        logic        flip_set[4];
        int k;
        int n;

        gravity_set = '{32'h7FFF_FFFF, 32'd0, 32'd642908, 32'd65536};
        flip_set = '{1'b1, 1'b0, 1'b1, 1'b0};

        // Directed faces; the obvious ones carry their residuals.
        f = '{31'd65536, 0, 0, 31'd65536, 0, 0, 0, 0, 32'sd1234, -32'sd99, 32'sd7};
        rows.push_back('{f, 1'b1, '{32'sd1234, -32'sd99, 32'sd7, 1'b0}});
        f = '{31'd0, QMAX, QMIN, 31'h7FFF_FFFF, QMAX, QMIN, QMAX, QMIN, QMIN, QMIN, QMIN};
        rows.push_back('{f, 1'b1, '{QMAX, QMAX, QMAX, 1'b1}});
        f = '{31'h7FFF_FFFF, 0, 0, 31'd0, 0, 0, 0, 0, 0, 0, 0};
        rows.push_back('{f, 1'b1, '{QMAX, QMAX, QMAX, 1'b1}});
        f = '{31'd0, 0, 0, 31'd0, 0, 0, 0, 0, 0, 0, 0};
        rows.push_back('{f, 1'b1, '{QMAX, QMAX, QMAX, 1'b1}});
        f = '{31'h7FFF_FFFF, QMAX, QMAX, 31'h7FFF_FFFF, QMAX, QMAX, QMAX, QMAX,
              QMAX, QMAX, QMAX};
        rows.push_back('{f, 1'b0, '0});
        f = '{31'd1, QMIN, QMAX, 31'd1, QMAX, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN};
        rows.push_back('{f, 1'b0, '0});
        f = '{31'd65536, 32'sd131072, -32'sd65536, 31'd131072, -32'sd32768,
              32'sd65536, 32'sd65536, 0, 0, 0, 0};
        rows.push_back('{f, 1'b0, '0});
        f = '{31'd3, -32'sd5, 32'sd5, 31'd7, 32'sd9, -32'sd9, QMIN, 32'sd1, 0, 0, 0};
        rows.push_back('{f, 1'b0, '0});
        f = '{31'h4000_0000, QMIN, QMIN, 31'h0000_8000, QMAX, QMAX, -32'sd65536,
              32'sd65536, QMAX, QMIN, QMAX};
        rows.push_back('{f, 1'b0, '0});
        for (k = 0; k < 6; k++) begin
            rows.push_back('{random_face(), 1'b0, '0});
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_mode = 0;
        foreach (rows[k]) begin
            pending_rows.push_back(rows[k]);
            send_face(rows[k].face);
        end

        // Random faces across register settings and idling modes.
        for (n = 0; n < 6; n++) begin
            drain_pipeline();
            write_register(REG_GRAVITY, gravity_set[n % 4]);
            write_register(REG_FLIP, {31'($urandom()), flip_set[n % 4]});
            idle_mode = n / 2;
            for (k = 0; k < BLOCK_ITEMS; k++) begin
                row.face = random_face();
                row.typed = 1'b0;
                row.want = '0;
                pending_rows.push_back(row);
                send_face(row.face);
            end
        end

        drain_pipeline();
        $display("%0d faces accepted, %0d results checked, %0d zero-depth faults,",
                 faces_sent, results_seen, faults_seen);
        $display("input stalled for %0d cycles; gravity and normal flip swept to extremes",
                 stall_seen);
        if (failures == 0 && residual_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
